// ----- hw/rtl/tas_pkg.sv -----
package tas_pkg;

    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned IDX_W     = $clog2(NUM_REGS);
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [IDX_W-1:0] REG_THRESHOLD  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_FULL_SCALE = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_INITIAL    = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_DUTY_MIN   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_DUTY_MAX   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_WATCHDOG   = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_COAST      = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_FRAME_ID   = IDX_W'(7);

    localparam logic [15:0] THRESHOLD_RST  = 16'd200;
    localparam logic [15:0] FULL_SCALE_RST = 16'd1811;
    localparam logic [15:0] INITIAL_RST    = 16'd172;
    localparam logic [15:0] DUTY_MIN_RST   = 16'd0;
    localparam logic [15:0] DUTY_MAX_RST   = 16'd999;
    localparam logic [15:0] WATCHDOG_RST   = 16'd500;
    localparam logic [15:0] COAST_RST      = 16'd1000;
    localparam logic [10:0] FRAME_ID_RST   = 11'd256;

    localparam logic [15:0] AGE_MAX       = 16'hFFFF;
    localparam logic [3:0]  MIN_FRAME_LEN = 4'd2;

    localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_CODE_READY    = 3'd1;
    localparam logic [2:0] MODE_CODE_SMOKING  = 3'd2;
    localparam logic [2:0] MODE_CODE_COAST    = 3'd3;
    localparam logic [2:0] MODE_CODE_SAFE_OFF = 3'd4;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_READY    = 5'b00010,
        MODE_SMOKING  = 5'b00100,
        MODE_COAST    = 5'b01000,
        MODE_SAFE_OFF = 5'b10000
    } mode_t;

    typedef struct packed {
        logic [15:0] threshold;
        logic [15:0] full_scale;
        logic [15:0] initial_value;
        logic [15:0] duty_min;
        logic [15:0] duty_max;
        logic [15:0] watchdog_ms;
        logic [15:0] coast_ms;
        logic [10:0] frame_id;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic div_last;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
    } dp_status_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        unique case (m)
            MODE_IDLE:     code = MODE_CODE_IDLE;
            MODE_READY:    code = MODE_CODE_READY;
            MODE_SMOKING:  code = MODE_CODE_SMOKING;
            MODE_COAST:    code = MODE_CODE_COAST;
            MODE_SAFE_OFF: code = MODE_CODE_SAFE_OFF;
            default:       code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == AGE_MAX) ? AGE_MAX : v + 16'd1;
    endfunction

endpackage

// ----- hw/rtl/tas_regs.sv -----
module tas_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tas_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_data,
    output tas_pkg::cfg_t             cfg
);
    import tas_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:  cfg_next.threshold     = cfg_data;
                REG_FULL_SCALE: cfg_next.full_scale    = cfg_data;
                REG_INITIAL:    cfg_next.initial_value = cfg_data;
                REG_DUTY_MIN:   cfg_next.duty_min      = cfg_data;
                REG_DUTY_MAX:   cfg_next.duty_max      = cfg_data;
                REG_WATCHDOG:   cfg_next.watchdog_ms   = cfg_data;
                REG_COAST:      cfg_next.coast_ms      = cfg_data;
                REG_FRAME_ID:   cfg_next.frame_id      = cfg_data[10:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= THRESHOLD_RST;
            cfg_reg.full_scale    <= FULL_SCALE_RST;
            cfg_reg.initial_value <= INITIAL_RST;
            cfg_reg.duty_min      <= DUTY_MIN_RST;
            cfg_reg.duty_max      <= DUTY_MAX_RST;
            cfg_reg.watchdog_ms   <= WATCHDOG_RST;
            cfg_reg.coast_ms      <= COAST_RST;
            cfg_reg.frame_id      <= FRAME_ID_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/tas_ctrl.sv -----
module tas_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  tas_pkg::dp_status_t status,
    output tas_pkg::ctrl_cmd_t  cmd
);
    import tas_pkg::*;

    typedef enum logic [2:0] {
        ST_READY = 3'b001,
        ST_DIV   = 3'b010,
        ST_OUT   = 3'b100
    } st_t;

    st_t              state_reg;
    st_t              state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign in_stall  = (state_reg != ST_READY);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_READY:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    state_next = status.need_div ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // The result is copied into the output register once the
                // previous beat has gone or is leaving in this cycle.
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/tas_datapath.sv -----
module tas_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tas_pkg::cfg_t       cfg,
    input  tas_pkg::ctrl_cmd_t  cmd,
    output tas_pkg::dp_status_t status,
    input  logic                action,
    input  logic [10:0]         frame_id,
    input  logic [3:0]          frame_length,
    input  logic [7:0]          byte_low,
    input  logic [7:0]          byte_high,
    output logic [2:0]          mode,
    output logic [15:0]         pump_drive,
    output logic [15:0]         heater_duty,
    output logic [15:0]         throttle,
    output logic [15:0]         link_age,
    output logic                link_seen
);
    import tas_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [15:0] throttle_reg;
    logic [15:0] throttle_next;
    logic [15:0] age_reg;
    logic [15:0] age_next;
    logic [15:0] coast_reg;
    logic [15:0] coast_next;
    logic        seen_reg;
    logic        seen_next;
    logic [15:0] pump_reg;
    logic [15:0] heater_reg;
    logic        duty_upd;
    logic [15:0] duty_val;

    logic [31:0] quot_reg;
    logic [31:0] quot_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;

    logic [2:0]  mode_out_reg;
    logic [15:0] pump_out_reg;
    logic [15:0] heater_out_reg;
    logic [15:0] throttle_out_reg;
    logic [15:0] age_out_reg;
    logic        seen_out_reg;

    logic [15:0] age_inc;
    logic [15:0] coast_inc;
    logic        stale;
    logic        above;
    logic        span_pos;
    logic [15:0] span;
    logic [15:0] thr_diff;
    logic [31:0] product;
    logic [16:0] rem_shift;
    logic [17:0] trial;
    logic        fits;
    logic [31:0] quot_step;
    logic [15:0] rem_step;
    logic [15:0] clamped;

    assign age_inc   = sat_inc(age_reg);
    assign coast_inc = sat_inc(coast_reg);
    assign stale     = age_inc > cfg.watchdog_ms;
    assign above     = throttle_reg > cfg.threshold;
    assign span_pos  = cfg.full_scale > cfg.threshold;
    assign span      = cfg.full_scale - cfg.threshold;
    assign thr_diff  = throttle_reg - cfg.threshold;
    assign product   = 32'(thr_diff) * 32'(cfg.duty_max);

    // One restoring division step: the remainder stays below the span.
    assign rem_shift = {rem_reg, quot_reg[31]};
    assign trial     = {1'b0, rem_shift} - {2'b00, span};
    assign fits      = !trial[17];
    assign quot_step = {quot_reg[30:0], fits};
    assign rem_step  = fits ? trial[15:0] : rem_shift[15:0];
    assign clamped   = (quot_step > {16'd0, cfg.duty_max}) ? cfg.duty_max : quot_step[15:0];

    always_comb
    begin
        mode_next       = mode_reg;
        throttle_next   = throttle_reg;
        age_next        = age_reg;
        coast_next      = coast_reg;
        seen_next       = seen_reg;
        duty_upd        = 1'b0;
        duty_val        = cfg.duty_min;
        status.need_div = 1'b0;
        if (cmd.accept)
        begin
            if (action)
            begin
                age_next  = '0;
                seen_next = 1'b1;
                if (frame_id == cfg.frame_id && frame_length >= MIN_FRAME_LEN)
                begin
                    throttle_next = {byte_high, byte_low};
                end
            end
            else
            begin
                age_next   = age_inc;
                coast_next = coast_inc;
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        duty_upd = 1'b1;
                        if (seen_reg)
                        begin
                            mode_next = MODE_READY;
                        end
                    end
                    MODE_READY:
                    begin
                        if (stale)
                        begin
                            mode_next = MODE_SAFE_OFF;
                        end
                        else
                        begin
                            duty_upd = 1'b1;
                            if (above)
                            begin
                                mode_next = MODE_SMOKING;
                            end
                        end
                    end
                    MODE_SMOKING:
                    begin
                        if (stale)
                        begin
                            mode_next = MODE_SAFE_OFF;
                        end
                        else if (!above)
                        begin
                            coast_next = '0;
                            duty_upd   = 1'b1;
                            mode_next  = MODE_COAST;
                        end
                        else if (!span_pos)
                        begin
                            duty_upd = 1'b1;
                            duty_val = cfg.duty_max;
                        end
                        else
                        begin
                            status.need_div = 1'b1;
                        end
                    end
                    MODE_COAST:
                    begin
                        if (stale)
                        begin
                            mode_next = MODE_SAFE_OFF;
                        end
                        else
                        begin
                            duty_upd = 1'b1;
                            if (above)
                            begin
                                mode_next = MODE_SMOKING;
                            end
                            else if (coast_inc >= cfg.coast_ms)
                            begin
                                mode_next = MODE_READY;
                            end
                        end
                    end
                    MODE_SAFE_OFF:
                    begin
                        duty_upd = 1'b1;
                        if (seen_reg && age_inc < cfg.watchdog_ms)
                        begin
                            mode_next = MODE_READY;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                    end
                endcase
            end
        end
        if (cmd.div_last)
        begin
            duty_upd = 1'b1;
            duty_val = clamped;
        end
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (status.need_div)
        begin
            quot_next = product;
            rem_next  = '0;
        end
        else if (cmd.div_step)
        begin
            quot_next = quot_step;
            rem_next  = rem_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            throttle_reg <= INITIAL_RST;
            age_reg      <= '0;
            coast_reg    <= '0;
            seen_reg     <= 1'b0;
            pump_reg     <= DUTY_MIN_RST;
            heater_reg   <= DUTY_MIN_RST;
        end
        else
        begin
            mode_reg     <= mode_next;
            throttle_reg <= throttle_next;
            age_reg      <= age_next;
            coast_reg    <= coast_next;
            seen_reg     <= seen_next;
            if (duty_upd)
            begin
                pump_reg   <= duty_val;
                heater_reg <= duty_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (cmd.load_out)
        begin
            mode_out_reg     <= mode_code(mode_reg);
            pump_out_reg     <= pump_reg;
            heater_out_reg   <= heater_reg;
            throttle_out_reg <= throttle_reg;
            age_out_reg      <= age_reg;
            seen_out_reg     <= seen_reg;
        end
    end

    assign mode        = mode_out_reg;
    assign pump_drive  = pump_out_reg;
    assign heater_duty = heater_out_reg;
    assign throttle    = throttle_out_reg;
    assign link_age    = age_out_reg;
    assign link_seen   = seen_out_reg;

endmodule

// ----- hw/rtl/throttle_actuator_supervisor_unit.sv -----
// Throttle actuator supervisor. Each input beat is a one-millisecond tick or a
// received bus frame, and each yields exactly one result beat showing mode,
// both duties, throttle, link age and whether a link has been seen. Frames and
// most ticks go from acceptance to the output state, which loads the result into
// the output register; the input stays stalled until the block is ready again.
// A non-stale tick in smoking mode with the throttle above the threshold and a
// positive span computes (throttle - threshold) * duty_max / span with a 16x16
// multiplier and a restoring divider that retires one quotient bit per cycle
// before the output state. A stalled result beat holds the next item in the
// output state until the output register frees. The output register lets the
// next item be accepted while a result still waits downstream. The user must
// write registers through the configuration port only while the block is idle;
// the block does not enforce this. The initial throttle and minimum duty written later do not reload the running state.
module throttle_actuator_supervisor_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      action,
    input  logic [10:0]               frame_id,
    input  logic [3:0]                frame_length,
    input  logic [7:0]                byte_low,
    input  logic [7:0]                byte_high,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                mode,
    output logic [15:0]               pump_drive,
    output logic [15:0]               heater_duty,
    output logic [15:0]               throttle,
    output logic [15:0]               link_age,
    output logic                      link_seen,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tas_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_data
);
    import tas_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    tas_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tas_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .byte_low     (byte_low),
        .byte_high    (byte_high),
        .mode         (mode),
        .pump_drive   (pump_drive),
        .heater_duty  (heater_duty),
        .throttle     (throttle),
        .link_age     (link_age),
        .link_seen    (link_seen)
    );

    // Only one item is in flight, so an accepted beat always closes the input.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item was still in flight");

    a_duties_equal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pump_drive == heater_duty))
        else $error("pump and heater duties differ");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && $past(out_valid) && $past(link_seen)) |-> link_seen)
        else $error("link seen flag cleared after being set");

endmodule

// ----- dv/supervisor_check.sv -----
module supervisor_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic                      action,
    input  logic [10:0]               frame_id,
    input  logic [3:0]                frame_length,
    input  logic [7:0]                byte_low,
    input  logic [7:0]                byte_high,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [2:0]                mode,
    input  logic [15:0]               pump_drive,
    input  logic [15:0]               heater_duty,
    input  logic [15:0]               throttle,
    input  logic [15:0]               link_age,
    input  logic                      link_seen,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [tas_pkg::IDX_W-1:0] cfg_index,
    input  logic [15:0]               cfg_data,
    output int                        mismatches,
    output int                        outstanding
);
    import tas_pkg::*;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] pump;
        logic [15:0] heater;
        logic [15:0] throttle;
        logic [15:0] age;
        logic        seen;
    } status_t;

    cfg_t        settings;
    logic [2:0]  mode_now;
    logic [15:0] throttle_now;
    logic [15:0] age_now;
    logic [15:0] coast_now;
    logic [15:0] pump_now;
    logic [15:0] heater_now;
    logic        seen_now;
    status_t     owed_status[$];

    // Both actuators always run at the same duty.
    task automatic set_duties(input logic [15:0] duty);
        pump_now   = duty;
        heater_now = duty;
    endtask

    function automatic logic [15:0] smoke_duty(input logic [15:0] level);
        logic [31:0] lift;
        logic [31:0] span;
        logic [31:0] quotient;
        if (level <= settings.threshold)
            return settings.duty_min;
        // A full scale at or below the threshold leaves no span to divide by.
        if (settings.full_scale <= settings.threshold)
            return settings.duty_max;
        lift     = 32'(level - settings.threshold);
        span     = 32'(settings.full_scale - settings.threshold);
        quotient = (lift * 32'(settings.duty_max)) / span;
        return (quotient > 32'(settings.duty_max)) ? settings.duty_max : quotient[15:0];
    endfunction

    task automatic run_controller();
        logic stale;
        stale = age_now > settings.watchdog_ms;
        case (mode_now)
            MODE_CODE_IDLE:
            begin
                set_duties(settings.duty_min);
                if (seen_now)
                    mode_now = MODE_CODE_READY;
            end
            MODE_CODE_READY:
            begin
                if (stale)
                    mode_now = MODE_CODE_SAFE_OFF;
                else
                begin
                    set_duties(settings.duty_min);
                    if (throttle_now > settings.threshold)
                        mode_now = MODE_CODE_SMOKING;
                end
            end
            MODE_CODE_SMOKING:
            begin
                if (stale)
                    mode_now = MODE_CODE_SAFE_OFF;
                else if (throttle_now <= settings.threshold)
                begin
                    coast_now = '0;
                    set_duties(settings.duty_min);
                    mode_now = MODE_CODE_COAST;
                end
                else
                    set_duties(smoke_duty(throttle_now));
            end
            MODE_CODE_COAST:
            begin
                if (stale)
                    mode_now = MODE_CODE_SAFE_OFF;
                else
                begin
                    set_duties(settings.duty_min);
                    if (throttle_now > settings.threshold)
                        mode_now = MODE_CODE_SMOKING;
                    else if (coast_now >= settings.coast_ms)
                        mode_now = MODE_CODE_READY;
                end
            end
            MODE_CODE_SAFE_OFF:
            begin
                set_duties(settings.duty_min);
                if (seen_now && age_now < settings.watchdog_ms)
                    mode_now = MODE_CODE_READY;
            end
            default:
                mode_now = MODE_CODE_IDLE;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        status_t due;
        if (!rst_n)
        begin
            settings = '{THRESHOLD_RST, FULL_SCALE_RST, INITIAL_RST, DUTY_MIN_RST,
                         DUTY_MAX_RST, WATCHDOG_RST, COAST_RST, FRAME_ID_RST};
            mode_now     = MODE_CODE_IDLE;
            throttle_now = INITIAL_RST;
            age_now      = '0;
            coast_now    = '0;
            seen_now     = 1'b0;
            pump_now     = DUTY_MIN_RST;
            heater_now   = DUTY_MIN_RST;
            owed_status.delete();
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            // The result of a beat accepted on this edge cannot leave on the same edge,
            // so the outgoing beat is matched before the incoming one is predicted.
            if (out_valid && !out_stall)
            begin
                if (owed_status.size() == 0)
                begin
                    $display("%0t: result beat with none outstanding: %s %0d %0d %0d",
                             $time, "mode pump throttle", mode, pump_drive, throttle);
                    mismatches++;
                end
                else
                begin
                    due = owed_status.pop_front();
                    check_field("mode", 16'(due.mode), 16'(mode));
                    check_field("pump_drive", due.pump, pump_drive);
                    check_field("heater_duty", due.heater, heater_duty);
                    check_field("throttle", due.throttle, throttle);
                    check_field("link_age", due.age, link_age);
                    check_field("link_seen", 16'(due.seen), 16'(link_seen));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (action)
                begin
                    age_now  = '0;
                    seen_now = 1'b1;
                    if (frame_id == settings.frame_id && frame_length >= MIN_FRAME_LEN)
                        throttle_now = {byte_high, byte_low};
                end
                else
                begin
                    age_now   = (age_now == AGE_MAX) ? AGE_MAX : age_now + 16'd1;
                    coast_now = (coast_now == AGE_MAX) ? AGE_MAX : coast_now + 16'd1;
                    run_controller();
                end
                owed_status.push_back('{mode_now, pump_now, heater_now, throttle_now,
                                        age_now, seen_now});
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD:  settings.threshold     = cfg_data;
                    REG_FULL_SCALE: settings.full_scale    = cfg_data;
                    REG_INITIAL:    settings.initial_value = cfg_data;
                    REG_DUTY_MIN:   settings.duty_min      = cfg_data;
                    REG_DUTY_MAX:   settings.duty_max      = cfg_data;
                    REG_WATCHDOG:   settings.watchdog_ms   = cfg_data;
                    REG_COAST:      settings.coast_ms      = cfg_data;
                    REG_FRAME_ID:   settings.frame_id      = cfg_data[10:0];
                    default: ;
                endcase
            end
            outstanding <= owed_status.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
module tb;
    import tas_pkg::*;

    localparam int QUIET_LIMIT = 2000;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic             action       = 1'b0;
    logic [10:0]      frame_id     = '0;
    logic [3:0]       frame_length = '0;
    logic [7:0]       byte_low     = '0;
    logic [7:0]       byte_high    = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    logic [2:0]       mode;
    logic [15:0]      pump_drive;
    logic [15:0]      heater_duty;
    logic [15:0]      throttle;
    logic [15:0]      link_age;
    logic             link_seen;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index    = '0;
    logic [15:0]      cfg_data     = '0;

    int mismatches;
    int outstanding;
    int stall_left   = 0;
    int quiet_cycles = 0;
    bit idle_on      = 1'b1;

    throttle_actuator_supervisor_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .byte_low     (byte_low),
        .byte_high    (byte_high),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mode         (mode),
        .pump_drive   (pump_drive),
        .heater_duty  (heater_duty),
        .throttle     (throttle),
        .link_age     (link_age),
        .link_seen    (link_seen),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    supervisor_check status_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .byte_low     (byte_low),
        .byte_high    (byte_high),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mode         (mode),
        .pump_drive   (pump_drive),
        .heater_duty  (heater_duty),
        .throttle     (throttle),
        .link_age     (link_age),
        .link_seen    (link_seen),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always #1 clk = ~clk;

    // Mostly no gap, sometimes a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            out_stall  <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Valid stays high from one beat to the next unless a gap is taken, so that
    // it never gets two assignments in the same step.
    task automatic send_beat(input logic act, input logic [10:0] fid,
                             input logic [3:0] flen, input logic [15:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        frame_id     <= fid;
        frame_length <= flen;
        byte_low     <= value[7:0];
        byte_high    <= value[15:8];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // The frame fields of a tick are ignored, so they carry noise.
    task automatic send_tick();
        send_beat(1'b0, 11'($urandom), 4'($urandom), 16'($urandom));
    endtask

    task automatic send_frame(input logic [10:0] fid, input logic [3:0] flen,
                              input logic [15:0] value);
        send_beat(1'b1, fid, flen, value);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_settings(input cfg_t c);
        write_reg(REG_THRESHOLD, c.threshold);
        write_reg(REG_FULL_SCALE, c.full_scale);
        write_reg(REG_INITIAL, c.initial_value);
        write_reg(REG_DUTY_MIN, c.duty_min);
        write_reg(REG_DUTY_MAX, c.duty_max);
        write_reg(REG_WATCHDOG, c.watchdog_ms);
        write_reg(REG_COAST, c.coast_ms);
        write_reg(REG_FRAME_ID, 16'(c.frame_id));
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t make_settings(input int kind);
        cfg_t c;
        c.threshold     = 16'($urandom_range(0, 3000));
        c.full_scale    = c.threshold + 16'($urandom_range(1, 4000));
        c.initial_value = 16'($urandom);
        c.duty_min      = 16'($urandom_range(0, 200));
        c.duty_max      = 16'($urandom);
        c.watchdog_ms   = 16'($urandom_range(0, 40));
        c.coast_ms      = 16'($urandom_range(0, 15));
        c.frame_id      = 11'($urandom);
        case (kind)
            0: c = '0;
            1: c = '1;
            2:
            begin
                c.threshold  = '0;
                c.full_scale = 16'hFFFF;
                c.duty_min   = '0;
                c.duty_max   = 16'hFFFF;
            end
            // Full scale at or below the threshold, unless the subtraction wraps below zero.
            3: c.full_scale = c.threshold - 16'($urandom_range(0, 100));
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] pick_level(input cfg_t c);
        case ($urandom_range(0, 9))
            0: return c.threshold;
            1: return c.threshold + 16'd1;
            2: return c.threshold - 16'd1;
            3: return 16'h0000;
            4: return 16'hFFFF;
            5: return c.full_scale;
            6: return c.full_scale + 16'd1;
            9: return 16'($urandom);
            default: return 16'($urandom_range(c.threshold, c.full_scale));
        endcase
    endfunction

    // Mostly ticks and well-formed throttle frames, with runs of ticks long enough
    // for the link watchdog and some foreign or short frames as noise.
    task automatic random_beats(input cfg_t c, output int n);
        int r;
        r = $urandom_range(0, 99);
        n = 1;
        if (r < 5)
        begin
            n = $urandom_range(4, 40);
            repeat (n) send_tick();
        end
        else if (r < 58)
            send_tick();
        else if (r < 83)
            send_frame(c.frame_id, 4'($urandom_range(2, 15)), pick_level(c));
        else if (r < 93)
            send_frame(11'($urandom), 4'($urandom), 16'($urandom));
        else
            send_frame(c.frame_id, 4'($urandom_range(0, 1)), 16'($urandom));
    endtask

    initial
    begin
        cfg_t mix;
        int   sent;
        int   n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: link not yet seen, foreign and short frames, clamp,
        // exact full scale, one step above the threshold, then back to coast.
        send_tick();
        send_frame(11'h7FF, 4'd8, 16'h1234);
        send_tick();
        send_frame(FRAME_ID_RST, 4'd1, 16'hFFFF);
        send_frame(FRAME_ID_RST, 4'd2, 16'hFFFF);
        send_tick();
        send_tick();
        send_frame(FRAME_ID_RST, 4'd15, FULL_SCALE_RST);
        send_tick();
        send_frame(FRAME_ID_RST, 4'd9, THRESHOLD_RST + 16'd1);
        send_tick();
        send_frame(FRAME_ID_RST, 4'd2, THRESHOLD_RST);
        send_tick();
        send_frame(FRAME_ID_RST, 4'd8, 16'h0000);
        send_tick();
        settle();

        // Zero span, short coast and a tight watchdog.
        mix = '{16'd0, 16'd0, 16'hFFFF, 16'd5, 16'hFFFF, 16'd3, 16'd2, 11'h7FF};
        write_settings(mix);
        send_frame(11'h7FF, 4'd2, 16'd1);
        send_tick();
        send_tick();
        send_frame(11'h7FF, 4'd2, 16'd0);
        repeat (5) send_tick();
        send_frame(11'h000, 4'd0, 16'hA5A5);
        send_tick();

        for (int phase = 0; phase < 10; phase++)
        begin
            settle();
            mix = make_settings(phase);
            write_settings(mix);
            idle_on = (phase % 4 != 3);
            sent = 0;
            while (sent < 115)
            begin
                random_beats(mix, n);
                sent += n;
            end
        end
        idle_on = 1'b1;
        settle();

        // A long watchdog and coast time keep the block in coast through a run
        // of ticks with no gaps.
        mix = '{16'd200, 16'd1811, 16'd0, 16'd3, 16'd999, 16'hFFFF, 16'hFFFF, FRAME_ID_RST};
        write_settings(mix);
        send_frame(FRAME_ID_RST, 4'd2, 16'd1000);
        repeat (3) send_tick();
        send_frame(FRAME_ID_RST, 4'd2, 16'd0);
        send_tick();
        idle_on = 1'b0;
        repeat (40) send_tick();
        idle_on = 1'b1;
        settle();
        mix.watchdog_ms = 16'hFFFE;
        write_settings(mix);
        repeat (2) send_tick();
        send_frame(11'h001, 4'd3, 16'h0000);
        send_tick();

        settle();
        repeat (36) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
